/* hw/rtl/fhm_pkg.sv */
// Package for the FDD HARQ-ACK mapper: field widths, mode and fill codes, beat type.
// No dependencies; imported by fhm_map and fdd_harq_ack_mapper_unit.
package fhm_pkg;

	localparam int NUM_CARRIERS = 5;
	localparam int BLOCKS       = 2 * NUM_CARRIERS;
	localparam int STATUS_W     = 2;
	localparam int BLOCK_BITS   = BLOCKS * STATUS_W;
	localparam int REPORT_W     = 10;
	localparam int COUNT_W      = 3;

	localparam logic [STATUS_W-1:0] ST_NOT_SENT = 2'd2;

	typedef enum logic [1:0] {
		MODE_NORMAL  = 2'd0,
		MODE_CHSEL   = 2'd1,
		MODE_FORMAT3 = 2'd2,
		MODE_ERROR   = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		FILL_NONE     = 2'd0,
		FILL_PRIMARY  = 2'd1,
		FILL_KEEP_DTX = 2'd2,
		FILL_BUNDLE   = 2'd3
	} fill_t;

	typedef struct packed {
		logic [1:0]            feedback_mode;
		logic [COUNT_W-1:0]    carrier_count;
		logic                  two_blocks;
		logic                  shared_channel_free;
		logic                  sched_request;
		logic                  csi_present;
		logic                  report_valid;
		logic [REPORT_W-1:0]   report_bits;
		logic [NUM_CARRIERS-1:0] present_mask;
		logic [BLOCK_BITS-1:0] block_status;
	} item_t;

endpackage

/* hw/rtl/fdd_harq_ack_mapper_unit.sv */
// FDD HARQ-ACK mapper top level: input register, fill logic, result register.
// Path: input register, fill logic, result register; the result register drives the outputs.
// Throughput: one beat per cycle unless out_stall holds the output with both registers full.
// Reset clears both valid flags; payload registers are not reset.
// Depends on fhm_pkg and fhm_map.
module fdd_harq_ack_mapper_unit #(
	parameter int CARRIERS = fhm_pkg::NUM_CARRIERS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [1:0]                          feedback_mode,
	input  logic [fhm_pkg::COUNT_W-1:0]         carrier_count,
	input  logic                                two_blocks,
	input  logic                                shared_channel_free,
	input  logic                                sched_request,
	input  logic                                csi_present,
	input  logic                                report_valid,
	input  logic [fhm_pkg::REPORT_W-1:0]        report_bits,
	input  logic [fhm_pkg::NUM_CARRIERS-1:0]    present_mask,
	input  logic [fhm_pkg::BLOCK_BITS-1:0]      block_status,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [fhm_pkg::BLOCK_BITS-1:0]      block_result,
	output logic [1:0]                          fill_used
);
	import fhm_pkg::*;

	item_t                 item_s1;
	logic                  valid_s1;
	logic                  valid_s2;
	logic [BLOCK_BITS-1:0] result_s2;
	fill_t                 fill_s2;
	logic [BLOCK_BITS-1:0] map_result;
	fill_t                 map_fill;
	logic                  load_s2;
	logic                  load_s1;

	assign load_s2  = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !load_s2;
	assign load_s1  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (load_s1 || load_s2) begin
				valid_s1 <= load_s1;
			end
			if (load_s2 || !out_stall) begin
				valid_s2 <= load_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			item_s1 <= '{feedback_mode: feedback_mode, carrier_count: carrier_count,
				two_blocks: two_blocks, shared_channel_free: shared_channel_free,
				sched_request: sched_request, csi_present: csi_present,
				report_valid: report_valid, report_bits: report_bits,
				present_mask: present_mask, block_status: block_status};
		end
		if (load_s2) begin
			result_s2 <= map_result;
			fill_s2   <= map_fill;
		end
	end

	fhm_map #(
		.CARRIERS (CARRIERS)
	) u_map (
		.item   (item_s1),
		.result (map_result),
		.fill   (map_fill)
	);

	assign out_valid    = valid_s2;
	assign block_result = result_s2;
	assign fill_used    = fill_s2;

	a_error_passes: assert property (@(posedge clk) disable iff (!arst_n)
		load_s2 && item_s1.feedback_mode == MODE_ERROR |=>
		block_result == $past(item_s1.block_status) && fill_used == FILL_NONE)
		else $error("error mode beat was modified");

	a_fill_none_only_on_error: assert property (@(posedge clk) disable iff (!arst_n)
		load_s2 && item_s1.feedback_mode != MODE_ERROR |=> fill_used != FILL_NONE)
		else $error("fill missing on a non-error beat");

	a_normal_keeps_secondary: assert property (@(posedge clk) disable iff (!arst_n)
		load_s2 && item_s1.feedback_mode == MODE_NORMAL |=>
		block_result[BLOCK_BITS-1:2*STATUS_W] ==
		$past(item_s1.block_status[BLOCK_BITS-1:2*STATUS_W]))
		else $error("normal mode touched a secondary carrier");

	a_stall_needs_held_beat: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && valid_s2 && out_stall)
		else $error("input stalled without a held beat");

endmodule

/* hw/rtl/fhm_map.sv */
// Combinational HARQ-ACK fill: chooses the fill and writes report bits into block status; error mode passes it through.
// Depends on fhm_pkg.
module fhm_map #(
	parameter int CARRIERS = fhm_pkg::NUM_CARRIERS
) (
	input  fhm_pkg::item_t                      item,
	output logic [fhm_pkg::BLOCK_BITS-1:0]      result,
	output fhm_pkg::fill_t                      fill
);
	import fhm_pkg::*;

	logic [COUNT_W-1:0] ncc;
	logic [BLOCKS-1:0]  sent;
	logic               others;
	logic               bit_v;

	always_comb begin
		ncc = (int'(item.carrier_count) > CARRIERS) ? COUNT_W'(CARRIERS) : item.carrier_count;
		for (int k = 0; k < BLOCKS; k++) begin
			sent[k] = item.block_status[k*STATUS_W +: STATUS_W] != ST_NOT_SENT;
		end
		others = 1'b0;
		for (int c = 1; c < NUM_CARRIERS; c++) begin
			for (int b = 0; b < 2; b++) begin
				if (COUNT_W'(c) < ncc && (b == 0 || item.two_blocks) &&
				    item.present_mask[c] && sent[2*c+b]) begin
					others = 1'b1;
				end
			end
		end
	end

	always_comb begin
		case (mode_t'(item.feedback_mode))
			MODE_NORMAL: fill = FILL_PRIMARY;
			MODE_CHSEL: begin
				if (ncc == COUNT_W'(1))           fill = FILL_PRIMARY;
				else if (item.shared_channel_free) fill = FILL_KEEP_DTX;
				else if (item.sched_request)       fill = FILL_BUNDLE;
				else if (item.csi_present)         fill = FILL_PRIMARY;
				else                               fill = FILL_KEEP_DTX;
			end
			MODE_FORMAT3: fill = others ? FILL_KEEP_DTX : FILL_PRIMARY;
			default: fill = FILL_NONE;
		endcase
	end

	always_comb begin
		result = item.block_status;
		bit_v  = 1'b0;
		case (fill)
			FILL_PRIMARY: begin
				if (item.present_mask[0]) begin
					if (sent[0]) begin
						result[1:0] = {1'b0, item.report_valid & item.report_bits[0]};
					end
					if (item.two_blocks && sent[1]) begin
						bit_v = sent[0] ? item.report_bits[1] : item.report_bits[0];
						result[3:2] = {1'b0, item.report_valid & bit_v};
					end
				end
			end
			FILL_KEEP_DTX, FILL_BUNDLE: begin
				for (int c = 0; c < NUM_CARRIERS; c++) begin
					for (int b = 0; b < 2; b++) begin
						if (COUNT_W'(c) < ncc && item.present_mask[c] &&
						    (b == 0 || item.two_blocks) && sent[2*c+b]) begin
							if (fill == FILL_BUNDLE) begin
								result[(2*c+b)*STATUS_W +: STATUS_W] =
									{1'b0, item.report_bits[c]};
							end else if (item.two_blocks) begin
								result[(2*c+b)*STATUS_W +: STATUS_W] =
									{1'b0, item.report_valid & item.report_bits[2*c+b]};
							end else begin
								result[(2*c+b)*STATUS_W +: STATUS_W] =
									{1'b0, item.report_valid & item.report_bits[c]};
							end
						end
					end
				end
			end
			default: result = item.block_status;
		endcase
	end

endmodule

/* tb/sv/testbench.sv */
// Self-checking bench for fdd_harq_ack_mapper_unit: directed and random HARQ-ACK reports,
// each predicted in a scoreboard class and compared field by field on the result channel.
// Depends on fhm_pkg and the mapper RTL.
`timescale 1ns / 100ps

module testbench;
	import fhm_pkg::*;

	class harq_scoreboard;
		typedef struct packed {
			logic [BLOCK_BITS-1:0] status;
			fill_t                 fill;
		} outcome_t;

		outcome_t awaited[$];
		int errors = 0;

		function void note(item_t it);
			logic [BLOCK_BITS-1:0] st;
			fill_t fill;
			int ncc, nb, idx, k, c, b;
			bit others;
			st = it.block_status;
			ncc = it.carrier_count;
			if (ncc > NUM_CARRIERS)
				ncc = NUM_CARRIERS;
			nb = it.two_blocks ? 2 : 1;
			others = 1'b0;
			idx = 0;
			case (it.feedback_mode)
				MODE_NORMAL: fill = FILL_PRIMARY;
				MODE_CHSEL: begin
					if (ncc == 1) fill = FILL_PRIMARY;
					else if (it.shared_channel_free) fill = FILL_KEEP_DTX;
					else if (it.sched_request) fill = FILL_BUNDLE;
					else if (it.csi_present) fill = FILL_PRIMARY;
					else fill = FILL_KEEP_DTX;
				end
				MODE_FORMAT3: begin
					for (c = 1; c < ncc; c++)
						for (b = 0; b < nb; b++)
							if (it.present_mask[c] && st[(2*c+b)*2 +: 2] != ST_NOT_SENT)
								others = 1'b1;
					fill = others ? FILL_KEEP_DTX : FILL_PRIMARY;
				end
				default: fill = FILL_NONE;
			endcase
			if (fill == FILL_PRIMARY) begin
				if (it.present_mask[0]) begin
					for (b = 0; b < nb; b++) begin
						k = 2 * b;
						if (st[k +: 2] != ST_NOT_SENT) begin
							if (it.report_valid) begin
								st[k +: 2] = {1'b0, it.report_bits[idx]};
								idx++;
							end else begin
								st[k +: 2] = 2'd0;
							end
						end
					end
				end
			end else if (fill != FILL_NONE) begin
				for (c = 0; c < ncc; c++) begin
					if (!it.present_mask[c])
						continue;
					for (b = 0; b < nb; b++) begin
						k = (2 * c + b) * 2;
						if (st[k +: 2] == ST_NOT_SENT)
							continue;
						if (fill == FILL_BUNDLE)
							st[k +: 2] = {1'b0, it.report_bits[c]};
						else if (it.report_valid)
							st[k +: 2] = {1'b0, it.report_bits[c * nb + b]};
						else
							st[k +: 2] = 2'd0;
					end
				end
			end
			awaited.push_back('{status: st, fill: fill});
		endfunction

		function void check(logic [BLOCK_BITS-1:0] res, logic [1:0] fill);
			outcome_t exp;
			if (awaited.size() == 0) begin
				$error("unexpected beat: block_result %h fill_used %0d", res, fill);
				errors++;
				return;
			end
			exp = awaited.pop_front();
			if (res !== exp.status) begin
				$error("block_result: expected %h, actual %h", exp.status, res);
				errors++;
			end
			if (fill !== exp.fill) begin
				$error("fill_used: expected %0d, actual %0d", exp.fill, fill);
				errors++;
			end
		endfunction

		function int pending();
			return awaited.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic out_valid;
	logic out_stall;
	item_t beat;
	logic [BLOCK_BITS-1:0] block_result;
	logic [1:0] fill_used;
	bit calm = 1'b0;

	harq_scoreboard board = new();

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	fdd_harq_ack_mapper_unit dut (
		.clk                 (clk),
		.arst_n              (arst_n),
		.in_valid            (in_valid),
		.in_stall            (in_stall),
		.feedback_mode       (beat.feedback_mode),
		.carrier_count       (beat.carrier_count),
		.two_blocks          (beat.two_blocks),
		.shared_channel_free (beat.shared_channel_free),
		.sched_request       (beat.sched_request),
		.csi_present         (beat.csi_present),
		.report_valid        (beat.report_valid),
		.report_bits         (beat.report_bits),
		.present_mask        (beat.present_mask),
		.block_status        (beat.block_status),
		.out_valid           (out_valid),
		.out_stall           (out_stall),
		.block_result        (block_result),
		.fill_used           (fill_used)
	);

	function automatic item_t make_report(mode_t mode, int ncc, bit nb2, bit pusch, bit sr,
			bit csi, bit valid, logic [REPORT_W-1:0] bits, logic [NUM_CARRIERS-1:0] pres,
			logic [BLOCK_BITS-1:0] st);
		item_t it;
		it.feedback_mode       = mode;
		it.carrier_count       = COUNT_W'(ncc);
		it.two_blocks          = nb2;
		it.shared_channel_free = pusch;
		it.sched_request       = sr;
		it.csi_present         = csi;
		it.report_valid        = valid;
		it.report_bits         = bits;
		it.present_mask        = pres;
		it.block_status        = st;
		return it;
	endfunction

	function automatic item_t random_report();
		item_t it;
		int k;
		it.feedback_mode       = 2'($urandom_range(0, 3));
		it.carrier_count       = ($urandom_range(0, 7) == 0) ? COUNT_W'($urandom_range(0, 7))
		                                                     : COUNT_W'($urandom_range(1, 5));
		it.two_blocks          = 1'($urandom);
		it.shared_channel_free = 1'($urandom);
		it.sched_request       = 1'($urandom);
		it.csi_present         = 1'($urandom);
		it.report_valid        = ($urandom_range(0, 3) != 0);
		it.report_bits         = REPORT_W'($urandom);
		it.present_mask        = NUM_CARRIERS'($urandom);
		if ($urandom_range(0, 7) == 0) begin
			it.block_status = BLOCK_BITS'($urandom);
		end else begin
			for (k = 0; k < BLOCKS; k++)
				it.block_status[2*k +: 2] = ($urandom_range(0, 7) < 3) ? ST_NOT_SENT
				                                                       : 2'($urandom_range(0, 3));
		end
		return it;
	endfunction

	task automatic push_report(input item_t it);
		beat     <= it;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		board.note(it);
		@(negedge clk);
	endtask

	task automatic hold_off(input int cycles);
		in_valid <= 1'b0;
		repeat (cycles) @(negedge clk);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		do @(negedge clk); while (board.pending() != 0);
	endtask

	initial begin
		out_stall = 1'b0;
		forever begin
			repeat ($urandom_range(1, 40)) @(negedge clk);
			if (!calm) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 16)) @(negedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk)
		if (arst_n && out_valid && !out_stall)
			board.check(block_result, fill_used);

	initial begin
		item_t directed[$];
		int n;
		arst_n   = 1'b0;
		in_valid = 1'b0;
		beat     = '0;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		directed.push_back(make_report(MODE_NORMAL, 1, 1, 0, 0, 0, 1, 10'h3FF, 5'h01, 20'h00000));
		directed.push_back(make_report(MODE_NORMAL, 5, 1, 1, 1, 1, 0, 10'h3FF, 5'h1F, 20'hFFFFF));
		directed.push_back(make_report(MODE_NORMAL, 1, 1, 0, 0, 0, 1, 10'h001, 5'h01, 20'h55556));
		directed.push_back(make_report(MODE_NORMAL, 2, 1, 0, 0, 0, 1, 10'h3FF, 5'h1E, 20'h00000));
		directed.push_back(make_report(MODE_CHSEL, 1, 1, 1, 1, 0, 1, 10'h002, 5'h1F, 20'h00000));
		directed.push_back(make_report(MODE_CHSEL, 3, 1, 1, 0, 0, 1, 10'h2A5, 5'h1F, 20'h00000));
		directed.push_back(make_report(MODE_CHSEL, 3, 1, 0, 1, 0, 0, 10'h005, 5'h1F, 20'h00000));
		directed.push_back(make_report(MODE_CHSEL, 3, 0, 0, 0, 1, 1, 10'h3FF, 5'h1F, 20'h00000));
		directed.push_back(make_report(MODE_CHSEL, 3, 1, 0, 0, 0, 1, 10'h15A, 5'h1F, 20'h0FFFF));
		directed.push_back(make_report(MODE_CHSEL, 4, 1, 0, 0, 0, 0, 10'h3FF, 5'h1F, 20'hFFFFF));
		directed.push_back(make_report(MODE_FORMAT3, 5, 1, 0, 0, 0, 1, 10'h3FF, 5'h1F, 20'h00000));
		directed.push_back(make_report(MODE_FORMAT3, 5, 1, 0, 0, 0, 1, 10'h3FF, 5'h1F, 20'hAAAA0));
		directed.push_back(make_report(MODE_FORMAT3, 5, 1, 0, 0, 0, 1, 10'h3FF, 5'h01, 20'h00000));
		directed.push_back(make_report(MODE_FORMAT3, 5, 0, 0, 0, 0, 0, 10'h000, 5'h10, 20'h00300));
		directed.push_back(make_report(MODE_ERROR, 5, 1, 1, 1, 1, 1, 10'h3FF, 5'h1F, 20'h12345));
		directed.push_back(make_report(MODE_CHSEL, 0, 1, 1, 0, 0, 1, 10'h3FF, 5'h1F, 20'h00000));
		directed.push_back(make_report(MODE_NORMAL, 0, 1, 0, 0, 0, 1, 10'h3FF, 5'h1F, 20'h00000));
		directed.push_back(make_report(MODE_CHSEL, 7, 1, 1, 0, 0, 1, 10'h3FF, 5'h1F, 20'h00000));
		directed.push_back(make_report(MODE_CHSEL, 6, 1, 0, 1, 0, 1, 10'h01A, 5'h1F, 20'hFFFFF));
		directed.push_back(make_report(MODE_CHSEL, 5, 0, 1, 0, 0, 1, 10'h3E0, 5'h15, 20'h33333));
		directed.push_back(make_report(MODE_NORMAL, 0, 0, 0, 0, 0, 0, 10'h000, 5'h00, 20'h00000));
		directed.push_back(make_report(MODE_ERROR, 7, 1, 1, 1, 1, 1, 10'h3FF, 5'h1F, 20'hFFFFF));
		foreach (directed[i])
			push_report(directed[i]);
		drain_results();

		for (n = 0; n < 1150; n++) begin
			if (n == 1000)
				calm = 1'b1;
			if (n == 500)
				drain_results();
			else if (!calm && $urandom_range(0, 3) == 0)
				hold_off($urandom_range(1, 16));
			push_report(random_report());
		end

		drain_results();
		repeat (8) @(negedge clk);
		if (board.pending() != 0)
			$error("%0d expected results never arrived", board.pending());
		if (board.errors == 0 && board.pending() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule
